FILE: hdl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the line follower steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DUTY_WIDTH  = 8;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [4:0] SENSE_LIGHT_CAL = 5'h04;
    localparam logic [4:0] SENSE_DARK_CAL  = 5'h1B;
    localparam logic [4:0] SENSE_MASK      = 5'h1F;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_TURN_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_TURN_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT    = 3'd5;

    localparam logic [DUTY_WIDTH-1:0] RST_FAST_SPEED      = 8'd220;
    localparam logic [DUTY_WIDTH-1:0] RST_SOFT_TURN_SPEED = 8'd210;
    localparam logic [DUTY_WIDTH-1:0] RST_HARD_TURN_SPEED = 8'd190;
    localparam logic [DUTY_WIDTH-1:0] RST_WHEEL_OFFSET    = 8'd20;
    localparam logic [DUTY_WIDTH-1:0] RST_SOFT_OFFSET     = 8'd20;
    localparam logic [CFG_WIDTH-1:0]  RST_LOST_TIMEOUT    = 16'd31250;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_FWD   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [DUTY_WIDTH-1:0] fast_speed;
        logic [DUTY_WIDTH-1:0] soft_turn_speed;
        logic [DUTY_WIDTH-1:0] hard_turn_speed;
        logic [DUTY_WIDTH-1:0] wheel_offset;
        logic [DUTY_WIDTH-1:0] soft_offset;
        logic [CFG_WIDTH-1:0]  lost_timeout;
    } cfg_t;

    typedef struct packed {
        logic                   is_calibrated;
        logic                   line_is_dark;
        logic                   timing_active;
        logic [COUNT_WIDTH-1:0] lost_count;
        logic [DUTY_WIDTH-1:0]  first_duty;
        logic [DUTY_WIDTH-1:0]  second_duty;
        mode_t                  drive_mode;
    } state_t;

endpackage

FILE: hdl/line_follower_steering.sv
// ----------------------------------------------------------------------------
// line_follower_steering
// Steering controller for a five-sensor line follower: calibrates line
// polarity, selects wheel duties and drive mode, and stops on a lost line.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_*      in         tuser: op; tdata: sensors
//  m_*      out        tdata: duties, mode and status flags
//  cfg_*    in         register write, index and data
//
//  one item per cycle while s_tready is high; the next state is computed
//  from the state registers and incoming transfer, stored with the result
//  reset clears the state, the registers to their defaults and both valids
//  a stalled result waits in the output register while one more item goes
//  to the skid register; s_tready drops only when the skid register is full
// ----------------------------------------------------------------------------
module line_follower_steering (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [4:0] sensors
    input  logic                             s_tuser,   // [0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] left_speed, [15:8] right_speed, [17:16] motor_mode,
    // [18] calibrated, [19] dark_line, [20] lost_timing
    output logic [23:0]                      m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfs_pkg::CFG_WIDTH-1:0]    cfg_wdata
);
    import lfs_pkg::*;

    cfg_t        cfg_reg;
    state_t      state_reg;
    state_t      state_next;
    logic        s_xfer;
    logic        m_xfer;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic [23:0] out_data_reg;
    logic [23:0] skid_data_reg;
    logic [23:0] result;

    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    lfs_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .op      (s_tuser),
        .sensors (s_tdata[4:0]),
        .nxt     (state_next)
    );

    assign result = {3'b000, state_next.timing_active, state_next.line_is_dark,
                     state_next.is_calibrated, state_next.drive_mode,
                     state_next.second_duty, state_next.first_duty};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_speed      <= RST_FAST_SPEED;
            cfg_reg.soft_turn_speed <= RST_SOFT_TURN_SPEED;
            cfg_reg.hard_turn_speed <= RST_HARD_TURN_SPEED;
            cfg_reg.wheel_offset    <= RST_WHEEL_OFFSET;
            cfg_reg.soft_offset     <= RST_SOFT_OFFSET;
            cfg_reg.lost_timeout    <= RST_LOST_TIMEOUT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FAST_SPEED:      cfg_reg.fast_speed      <= cfg_wdata[DUTY_WIDTH-1:0];
                REG_SOFT_TURN_SPEED: cfg_reg.soft_turn_speed <= cfg_wdata[DUTY_WIDTH-1:0];
                REG_HARD_TURN_SPEED: cfg_reg.hard_turn_speed <= cfg_wdata[DUTY_WIDTH-1:0];
                REG_WHEEL_OFFSET:    cfg_reg.wheel_offset    <= cfg_wdata[DUTY_WIDTH-1:0];
                REG_SOFT_OFFSET:     cfg_reg.soft_offset     <= cfg_wdata[DUTY_WIDTH-1:0];
                REG_LOST_TIMEOUT:    cfg_reg.lost_timeout    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg  <= skid_valid_reg || s_xfer;
                skid_valid_reg <= 1'b0;
            end else if (s_xfer) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (s_xfer && out_valid_reg && !m_tready) begin
            skid_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.is_calibrated |=> state_reg.is_calibrated)
        else $error("calibration lost without reset");

    a_flags_need_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.line_is_dark || state_reg.timing_active) |-> state_reg.is_calibrated)
        else $error("polarity or lost timing set before calibration");

    a_off_means_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.drive_mode == MODE_OFF) |->
            (state_reg.first_duty == '0 && state_reg.second_duty == '0))
        else $error("motors off with nonzero duty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer == 1'b0 && out_valid_reg) |=> $stable(out_data_reg))
        else $error("stalled result changed");
`endif

endmodule

FILE: hdl/lfs_step.sv
// ----------------------------------------------------------------------------
// lfs_step
// Next-state logic for one tick or sensor sample: calibration, steering
// priority select with saturating duties, and the lost-line counter.
// ----------------------------------------------------------------------------
module lfs_step (
    input  lfs_pkg::cfg_t   cfg,
    input  lfs_pkg::state_t cur,
    input  logic            op,
    input  logic [4:0]      sensors,
    output lfs_pkg::state_t nxt
);
    import lfs_pkg::*;

    logic [4:0]             d;
    logic [DUTY_WIDTH:0]    wo_plus_so;
    logic [DUTY_WIDTH-1:0]  hard_sub;
    logic [DUTY_WIDTH-1:0]  soft_sub_wo;
    logic [DUTY_WIDTH-1:0]  soft_sub_so;
    logic [DUTY_WIDTH-1:0]  soft_sub_both;
    logic [DUTY_WIDTH-1:0]  fast_sub;
    logic [COUNT_WIDTH-1:0] count_inc;

    function automatic logic [DUTY_WIDTH-1:0] sat_sub(
        input logic [DUTY_WIDTH:0] a,
        input logic [DUTY_WIDTH:0] b
    );
        logic [DUTY_WIDTH:0] diff;
        diff = a - b;
        sat_sub = (a > b) ? diff[DUTY_WIDTH-1:0] : '0;
    endfunction

    always_comb begin
        d          = cur.line_is_dark ? (~sensors & SENSE_MASK) : sensors;
        wo_plus_so = {1'b0, cfg.wheel_offset} + {1'b0, cfg.soft_offset};

        hard_sub      = sat_sub({1'b0, cfg.hard_turn_speed}, {1'b0, cfg.wheel_offset});
        soft_sub_wo   = sat_sub({1'b0, cfg.soft_turn_speed}, {1'b0, cfg.wheel_offset});
        soft_sub_so   = sat_sub({1'b0, cfg.soft_turn_speed}, {1'b0, cfg.soft_offset});
        soft_sub_both = sat_sub({1'b0, cfg.soft_turn_speed}, wo_plus_so);
        fast_sub      = sat_sub({1'b0, cfg.fast_speed}, {1'b0, cfg.wheel_offset});

        count_inc = cur.lost_count + COUNT_WIDTH'(1);

        nxt = cur;
        if (op == OP_SAMPLE) begin
            if (!cur.is_calibrated) begin
                if (sensors == SENSE_LIGHT_CAL) begin
                    nxt.is_calibrated = 1'b1;
                    nxt.line_is_dark  = 1'b0;
                end else if (sensors == SENSE_DARK_CAL) begin
                    nxt.is_calibrated = 1'b1;
                    nxt.line_is_dark  = 1'b1;
                end
            end else if (d == '0) begin
                nxt.timing_active = 1'b1;
            end else begin
                nxt.timing_active = 1'b0;
                nxt.lost_count    = '0;
                // outer right, outer left, inner right, inner left, centre
                if (d[0]) begin
                    nxt.first_duty  = hard_sub;
                    nxt.second_duty = cfg.hard_turn_speed;
                    nxt.drive_mode  = MODE_RIGHT;
                end else if (d[4]) begin
                    nxt.first_duty  = hard_sub;
                    nxt.second_duty = cfg.hard_turn_speed;
                    nxt.drive_mode  = MODE_LEFT;
                end else if (d[1]) begin
                    nxt.first_duty  = soft_sub_wo;
                    nxt.second_duty = soft_sub_so;
                    nxt.drive_mode  = MODE_FWD;
                end else if (d[3]) begin
                    nxt.first_duty  = soft_sub_both;
                    nxt.second_duty = cfg.soft_turn_speed;
                    nxt.drive_mode  = MODE_FWD;
                end else begin
                    nxt.first_duty  = fast_sub;
                    nxt.second_duty = cfg.fast_speed;
                    nxt.drive_mode  = MODE_FWD;
                end
            end
        end else if (cur.is_calibrated && cur.timing_active) begin
            if (count_inc == COUNT_WIDTH'(cfg.lost_timeout)) begin
                nxt.first_duty    = '0;
                nxt.second_duty   = '0;
                nxt.drive_mode    = MODE_OFF;
                nxt.lost_count    = '0;
                nxt.timing_active = 1'b0;
            end else begin
                nxt.lost_count = count_inc;
            end
        end
    end

endmodule

FILE: test/steer_chk.sv
// ----------------------------------------------------------------------------
// steer_chk
// Watches the sensor, result and register ports of the line follower
// steering block. It keeps its own registers and steering state, predicts
// one result per accepted input transfer, and counts every result that
// differs from the oldest prediction or arrives with none waiting.
// ----------------------------------------------------------------------------
module steer_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [4:0] sensors
    input  logic                          s_tuser,   // [0] op
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] left_speed, [15:8] right_speed, [17:16] motor_mode,
    // [18] calibrated, [19] dark_line, [20] lost_timing
    input  logic [23:0]                   m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [lfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfs_pkg::CFG_WIDTH-1:0] cfg_wdata,
    output int                            errors,
    output int                            pending
);
    import lfs_pkg::*;

    typedef struct {
        logic [DUTY_WIDTH-1:0] left_speed;
        logic [DUTY_WIDTH-1:0] right_speed;
        mode_t                 motor_mode;
        logic                  calibrated;
        logic                  dark_line;
        logic                  lost_timing;
    } drive_word_t;

    cfg_t        regs;
    state_t      st;
    drive_word_t drive_queue[$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [DUTY_WIDTH-1:0] sat_sub(input logic [DUTY_WIDTH-1:0] a,
                                                      input logic [DUTY_WIDTH:0] b);
        return ({1'b0, a} > b) ? DUTY_WIDTH'({1'b0, a} - b) : '0;
    endfunction

    function automatic void set_drive(input logic [DUTY_WIDTH-1:0] first,
                                      input logic [DUTY_WIDTH-1:0] second, input mode_t m);
        st.first_duty  = first;
        st.second_duty = second;
        st.drive_mode  = m;
    endfunction

    // advance the steering state by one transfer and return what the block shows
    function automatic drive_word_t steer_step(input logic op, input logic [4:0] raw);
        logic [4:0]             seen;
        logic [COUNT_WIDTH-1:0] next_count;
        drive_word_t            w;
        if (op == OP_SAMPLE) begin
            if (!st.is_calibrated) begin
                if (raw == SENSE_LIGHT_CAL) begin
                    st.is_calibrated = 1'b1;
                    st.line_is_dark  = 1'b0;
                end else if (raw == SENSE_DARK_CAL) begin
                    st.is_calibrated = 1'b1;
                    st.line_is_dark  = 1'b1;
                end
            end else begin
                seen = st.line_is_dark ? (~raw & SENSE_MASK) : raw;
                if (seen == '0) begin
                    // count keeps its value, duties stay as they were
                    st.timing_active = 1'b1;
                end else begin
                    st.timing_active = 1'b0;
                    st.lost_count    = '0;
                    if (seen[0]) begin
                        set_drive(sat_sub(regs.hard_turn_speed, {1'b0, regs.wheel_offset}),
                                  regs.hard_turn_speed, MODE_RIGHT);
                    end else if (seen[4]) begin
                        set_drive(sat_sub(regs.hard_turn_speed, {1'b0, regs.wheel_offset}),
                                  regs.hard_turn_speed, MODE_LEFT);
                    end else if (seen[1]) begin
                        set_drive(sat_sub(regs.soft_turn_speed, {1'b0, regs.wheel_offset}),
                                  sat_sub(regs.soft_turn_speed, {1'b0, regs.soft_offset}),
                                  MODE_FWD);
                    end else if (seen[3]) begin
                        // both offsets summed without wrapping
                        set_drive(sat_sub(regs.soft_turn_speed,
                                          {1'b0, regs.wheel_offset} + {1'b0, regs.soft_offset}),
                                  regs.soft_turn_speed, MODE_FWD);
                    end else begin
                        set_drive(sat_sub(regs.fast_speed, {1'b0, regs.wheel_offset}),
                                  regs.fast_speed, MODE_FWD);
                    end
                end
            end
        end else if (st.is_calibrated && st.timing_active) begin
            next_count = st.lost_count + COUNT_WIDTH'(1);
            if (next_count == COUNT_WIDTH'(regs.lost_timeout)) begin
                set_drive('0, '0, MODE_OFF);
                st.lost_count    = '0;
                st.timing_active = 1'b0;
            end else begin
                st.lost_count = next_count;
            end
        end
        w.left_speed  = st.first_duty;
        w.right_speed = st.second_duty;
        w.motor_mode  = st.drive_mode;
        w.calibrated  = st.is_calibrated;
        w.dark_line   = st.line_is_dark;
        w.lost_timing = st.timing_active;
        return w;
    endfunction

    always @(posedge aclk) begin : track
        drive_word_t want;
        logic        bad;
        if (!aresetn) begin
            regs = '{fast_speed:      RST_FAST_SPEED,
                     soft_turn_speed: RST_SOFT_TURN_SPEED,
                     hard_turn_speed: RST_HARD_TURN_SPEED,
                     wheel_offset:    RST_WHEEL_OFFSET,
                     soft_offset:     RST_SOFT_OFFSET,
                     lost_timeout:    RST_LOST_TIMEOUT};
            st = '0;
            st.drive_mode = MODE_OFF;
            drive_queue.delete();
        end else begin
            // result side first: a result never belongs to the transfer of the same edge
            if (m_tvalid && m_tready) begin
                if (drive_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("steer_chk: result %h with nothing expected", m_tdata);
                end else begin
                    want = drive_queue.pop_front();
                    bad = (m_tdata[7:0] !== want.left_speed) ||
                          (m_tdata[15:8] !== want.right_speed) ||
                          (m_tdata[17:16] !== want.motor_mode) ||
                          (m_tdata[18] !== want.calibrated) ||
                          (m_tdata[19] !== want.dark_line) ||
                          (m_tdata[20] !== want.lost_timing);
                    if (bad) begin
                        errors++;
                        if (errors <= 10)
                            $display("steer_chk: expected left %0d right %0d mode %0d ",
                                     want.left_speed, want.right_speed, want.motor_mode,
                                     "cal %b dark %b lost %b, ", want.calibrated,
                                     want.dark_line, want.lost_timing,
                                     "got left %0d right %0d mode %0d cal %b dark %b lost %b",
                                     m_tdata[7:0], m_tdata[15:8], m_tdata[17:16],
                                     m_tdata[18], m_tdata[19], m_tdata[20]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                drive_queue.push_back(steer_step(s_tuser, s_tdata[4:0]));
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FAST_SPEED:      regs.fast_speed      = cfg_wdata[DUTY_WIDTH-1:0];
                    REG_SOFT_TURN_SPEED: regs.soft_turn_speed = cfg_wdata[DUTY_WIDTH-1:0];
                    REG_HARD_TURN_SPEED: regs.hard_turn_speed = cfg_wdata[DUTY_WIDTH-1:0];
                    REG_WHEEL_OFFSET:    regs.wheel_offset    = cfg_wdata[DUTY_WIDTH-1:0];
                    REG_SOFT_OFFSET:     regs.soft_offset     = cfg_wdata[DUTY_WIDTH-1:0];
                    REG_LOST_TIMEOUT:    regs.lost_timeout    = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending = drive_queue.size();
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the line follower steering block with sensor samples and ticks:
// a directed pass over calibration, every steering priority and the lost
// line timeout, then random traffic under several register settings and
// three flow control profiles, and finally a timeout lowered under a
// running lost-line count.
// ----------------------------------------------------------------------------
module tb;
    import lfs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BLOCKS      = 12;
    localparam int BLOCK_ITEMS = 92;
    localparam logic [4:0] STEER_CASES [9] = '{5'h01, 5'h10, 5'h02, 5'h08, 5'h04,
                                               5'h1F, 5'h1E, 5'h1C, 5'h0C};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_wdata;

    int         chk_errors;
    int         chk_pending;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         quiet_cycles;
    logic [4:0] polarity;  // xor mask that turns a line pattern into raw sensor bits

    line_follower_steering uut (.*);

    steer_chk check_steer (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(chk_errors), .pending(chk_pending)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // no transfer on either side for too long means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [4:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(31));
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_line(input logic [4:0] pattern);
        send_item(OP_SAMPLE, pattern ^ polarity);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 5'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (chk_pending != 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // junk in the upper byte of the duty writes and at the unused indexes
    task automatic load_settings(input logic [7:0] f_spd, input logic [7:0] s_spd,
                                 input logic [7:0] h_spd, input logic [7:0] w_ofs,
                                 input logic [7:0] s_ofs, input logic [15:0] tmo);
        int idx;
        drain();
        write_reg(REG_FAST_SPEED,      {8'($urandom), f_spd});
        write_reg(REG_SOFT_TURN_SPEED, {8'($urandom), s_spd});
        write_reg(REG_HARD_TURN_SPEED, {8'($urandom), h_spd});
        write_reg(REG_WHEEL_OFFSET,    {8'($urandom), w_ofs});
        write_reg(REG_SOFT_OFFSET,     {8'($urandom), s_ofs});
        write_reg(REG_LOST_TIMEOUT,    tmo);
        for (idx = int'(REG_LOST_TIMEOUT) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_settings();
        logic [15:0] tmo;
        logic [7:0]  ofs_top;
        tmo     = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12, 1));
        ofs_top = ($urandom_range(3) == 0) ? 8'd255 : 8'd60;
        load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(ofs_top)), 8'($urandom_range(ofs_top)), tmo);
    endtask

    // mostly ticks and all-clear samples so the timeout is reached often
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_tick();
        else if (pick < 62)
            send_line(5'h00);
        else
            send_item(OP_SAMPLE, 5'($urandom));
    endtask

    initial begin
        int blk;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = OP_TICK;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_FAST_SPEED;
        cfg_wdata    = '0;
        quiet_cycles = 0;
        polarity     = '0;
        tx_idle_pct  = 26;
        rx_idle_pct  = 67;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // not calibrated yet: ticks and other patterns leave everything at reset
        send_tick();
        send_item(OP_SAMPLE, 5'h00);
        send_item(OP_SAMPLE, SENSE_MASK);
        send_item(OP_SAMPLE, 5'h0A);
        polarity = $urandom_range(1) ? SENSE_MASK : '0;
        send_item(OP_SAMPLE, (polarity == SENSE_MASK) ? SENSE_DARK_CAL : SENSE_LIGHT_CAL);

        foreach (STEER_CASES[i])
            send_line(STEER_CASES[i]);

        // all-clear twice does not restart the count; a seen line clears it
        send_line(5'h00);
        send_tick();
        send_tick();
        send_line(5'h00);
        send_tick();
        send_line(5'h04);
        send_tick();

        load_settings(RST_FAST_SPEED, RST_SOFT_TURN_SPEED, RST_HARD_TURN_SPEED,
                      RST_WHEEL_OFFSET, RST_SOFT_OFFSET, 16'd3);
        send_line(5'h00);
        repeat (4) send_tick();

        for (blk = 0; blk < BLOCKS; blk++) begin
            if (blk == BLOCKS / 3) begin
                tx_idle_pct = 67;
                rx_idle_pct = 26;
            end
            if (blk == 2 * BLOCKS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (blk)
                0: load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1);
                1: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
                2: load_settings(8'd255, 8'd255, 8'd255, 8'd200, 8'd200, 16'd5);
                5: load_settings(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 16'd2);
                9: load_settings(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 16'd1);
                default: random_settings();
            endcase
            repeat (BLOCK_ITEMS) random_item();
        end

        // lower the timeout under a running count: no stop before the count wraps
        load_settings(RST_FAST_SPEED, RST_SOFT_TURN_SPEED, RST_HARD_TURN_SPEED,
                      RST_WHEEL_OFFSET, RST_SOFT_OFFSET, 16'd10);
        send_line(5'h04);
        send_line(5'h00);
        repeat (5) send_tick();
        load_settings(RST_FAST_SPEED, RST_SOFT_TURN_SPEED, RST_HARD_TURN_SPEED,
                      RST_WHEEL_OFFSET, RST_SOFT_OFFSET, 16'd3);
        repeat (12) send_tick();
        send_line(5'h04);

        drain();
        repeat (8) @(negedge aclk);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/lfs_pkg.sv
hdl/lfs_step.sv
hdl/line_follower_steering.sv
test/steer_chk.sv
test/tb.sv
